>>> rtl/mfrq_pkg.sv
// Shared types and codes for the multilevel FIFO run queue.
package mfrq_pkg;

  // Width of the thread identifier field and the id space it spans
  localparam int TID_W   = 6;
  localparam int NUM_IDS = 2 ** TID_W;
  localparam int LVL_W   = 5;
  localparam int AFF_W   = 8;
  localparam int CPU_W   = 3;

  // Request modes
  localparam logic [1:0] MODE_INSERT  = 2'd0;
  localparam logic [1:0] MODE_REMOVE  = 2'd1;
  localparam logic [1:0] MODE_EXTRACT = 2'd2;

  // Result status codes
  localparam logic [1:0] STAT_DONE    = 2'd0;
  localparam logic [1:0] STAT_EMPTY   = 2'd1;
  localparam logic [1:0] STAT_IGNORED = 2'd2;

  // Request transaction
  typedef struct packed {
    logic [1:0]       mode;
    logic [TID_W-1:0] thread_id;
    logic [LVL_W-1:0] priority_req;
    logic [AFF_W-1:0] affinity_mask;
    logic [CPU_W-1:0] cpu_id;
  } cmd_t;

  // Result transaction
  typedef struct packed {
    logic             found;
    logic [TID_W-1:0] chosen_thread;
    logic [1:0]       status;
  } rsp_t;

  // One queue slot
  typedef struct packed {
    logic             valid;
    logic [TID_W-1:0] tid;
    logic [LVL_W-1:0] level;
    logic [AFF_W-1:0] affinity;
  } cell_t;

  // What every slot does this cycle
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_DELETE
  } cell_op_t;

  // Control broadcast to the whole chain
  typedef struct packed {
    cell_op_t         op;
    cell_t            entry;
    logic [TID_W-1:0] key;
    logic [CPU_W-1:0] cpu_id;
    logic             cpu_ok;
  } cell_ctrl_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_APPLY
  } state_t;

endpackage

>>> rtl/mfrq_cell.sv
// One slot of the sorted run queue chain.
module mfrq_cell
  import mfrq_pkg::*;
#(
  parameter int USE_AFFINITY = 0
) (
  input  logic       clk,
  input  logic       rst,
  input  cell_ctrl_t ctrl,
  input  cell_t      left,
  input  logic       left_open,
  input  cell_t      right,
  input  logic       take_right,
  output cell_t      entry,
  output logic       open_slot,
  output logic       match,
  output logic       elig
);

  cell_t entry_next;

  // Slot is free or holds a strictly lower level: a new entry belongs here or earlier
  assign open_slot = !entry.valid || (entry.level < ctrl.entry.level);
  assign match     = entry.valid && (entry.tid == ctrl.key);

  // Eligible for extract
  always_comb begin
    if (USE_AFFINITY == 0) begin
      elig = entry.valid;
    end else begin
      elig = entry.valid && ctrl.cpu_ok && entry.affinity[ctrl.cpu_id];
    end
  end

  // Shift right on insert, shift left on delete
  always_comb begin
    entry_next = entry;
    unique case (ctrl.op)
      CELL_INSERT: begin
        if (left_open) begin
          entry_next = left;
        end else if (open_slot) begin
          entry_next = ctrl.entry;
        end
      end
      CELL_DELETE: begin
        if (take_right) begin
          entry_next = right;
        end
      end
      CELL_HOLD: begin
        entry_next = entry;
      end
      default: begin
        entry_next = entry;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry.valid <= 1'b0;
    end else begin
      entry <= entry_next;
    end
  end

endmodule

>>> rtl/mfrq_chain.sv
// Row of queue slots kept sorted by level, oldest first within a level.
module mfrq_chain
  import mfrq_pkg::*;
#(
  parameter int NUM_THREADS  = 64,
  parameter int USE_AFFINITY = 0
) (
  input  logic                   clk,
  input  logic                   rst,
  input  cell_ctrl_t             ctrl,
  input  logic [NUM_THREADS-1:0] kill,
  output logic [NUM_THREADS-1:0] match_vec,
  output logic [NUM_THREADS-1:0] elig_vec,
  output logic [TID_W-1:0]       kill_tid
);

  cell_t                  slot [NUM_THREADS];
  logic [NUM_THREADS-1:0] open_vec;
  logic [NUM_THREADS-1:0] shift_vec;
  cell_t                  empty_slot;

  assign empty_slot = '0;

  // Every slot at or past the killed one pulls from its right neighbor
  assign shift_vec = ~(kill - {{(NUM_THREADS-1){1'b0}}, 1'b1});

  // Cell row
  for (genvar i = 0; i < NUM_THREADS; i++) begin : g_cell
    cell_t left_i;
    logic  left_open_i;
    cell_t right_i;

    if (i == 0) begin : g_first
      assign left_i      = empty_slot;
      assign left_open_i = 1'b0;
    end else begin : g_mid
      assign left_i      = slot[i-1];
      assign left_open_i = open_vec[i-1];
    end

    if (i == NUM_THREADS - 1) begin : g_last
      assign right_i = empty_slot;
    end else begin : g_inner
      assign right_i = slot[i+1];
    end

    mfrq_cell #(
      .USE_AFFINITY(USE_AFFINITY)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .left      (left_i),
      .left_open (left_open_i),
      .right     (right_i),
      .take_right(shift_vec[i]),
      .entry     (slot[i]),
      .open_slot (open_vec[i]),
      .match     (match_vec[i]),
      .elig      (elig_vec[i])
    );
  end

  // Id of the slot being removed (kill is one-hot or zero)
  always_comb begin
    kill_tid = '0;
    for (int i = 0; i < NUM_THREADS; i++) begin
      kill_tid = kill_tid | (slot[i].tid & {TID_W{kill[i]}});
    end
  end

endmodule

>>> rtl/multilevel_fifo_run_queue.sv
// Top level of the multilevel FIFO run queue: sequencer, queued flags and slot chain.
//
// Run queue with one FIFO per priority level, held as a single row of slots
// sorted by level (highest first) and by arrival within a level. Issue a
// transaction by raising start while busy is low; the request is sampled at
// that edge. Every request passes through the sequencer steps sample,
// evaluate and apply, and its result appears on rsp with done high for exactly
// one cycle, on the cycle after the apply step; busy drops in that same cycle
// so the next request can be started then; requests are handled one at a
// time. There is no backpressure on the result side: capture rsp whenever
// done is high. Extract returns the first eligible slot of the row, which is
// the oldest thread at the highest level that has one; removals close the gap
// by shifting the tail of the row one slot left in the apply cycle.
module multilevel_fifo_run_queue
  import mfrq_pkg::*;
#(
  parameter int NUM_THREADS  = 64,
  parameter int NUM_LEVELS   = 32,
  parameter int NUM_CPUS     = 8,
  parameter int USE_AFFINITY = 0
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  cmd_t cmd,
  output rsp_t rsp,
  output logic done
);

  state_t                 state;
  state_t                 state_next;
  cmd_t                   req;
  logic [NUM_THREADS-1:0] kill;
  logic [NUM_THREADS-1:0] kill_next;
  logic                   do_insert;
  logic                   do_insert_next;
  logic [1:0]             eval_status;
  logic [1:0]             eval_status_next;
  logic [NUM_IDS-1:0]     queued;
  cell_ctrl_t             ctrl;
  logic [NUM_THREADS-1:0] match_vec;
  logic [NUM_THREADS-1:0] elig_vec;
  logic [NUM_THREADS-1:0] pick_vec;
  logic [TID_W-1:0]       kill_tid;
  logic                   tid_ok;
  logic [LVL_W-1:0]       sat_level;
  logic                   kill_any;

  // Request checks
  assign tid_ok   = int'(req.thread_id) < NUM_THREADS;
  assign kill_any = |kill;

  always_comb begin
    if (int'(req.priority_req) >= NUM_LEVELS) begin
      sat_level = LVL_W'(NUM_LEVELS - 1);
    end else begin
      sat_level = req.priority_req;
    end
  end

  // Lowest eligible slot
  assign pick_vec = elig_vec & (~elig_vec + {{(NUM_THREADS-1){1'b0}}, 1'b1});

  // Chain control
  always_comb begin
    ctrl.entry.valid    = 1'b1;
    ctrl.entry.tid      = req.thread_id;
    ctrl.entry.level    = sat_level;
    ctrl.entry.affinity = req.affinity_mask;
    ctrl.key            = req.thread_id;
    ctrl.cpu_id         = req.cpu_id;
    ctrl.cpu_ok         = int'(req.cpu_id) < NUM_CPUS;
    ctrl.op             = CELL_HOLD;
    if (state == ST_APPLY) begin
      ctrl.op = do_insert ? CELL_INSERT : CELL_DELETE;
    end
  end

  mfrq_chain #(
    .NUM_THREADS (NUM_THREADS),
    .USE_AFFINITY(USE_AFFINITY)
  ) u_chain (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (ctrl),
    .kill     (kill),
    .match_vec(match_vec),
    .elig_vec (elig_vec),
    .kill_tid (kill_tid)
  );

  // Evaluate: pick the slot to remove and the status
  always_comb begin
    kill_next        = '0;
    do_insert_next   = 1'b0;
    eval_status_next = STAT_DONE;
    unique case (req.mode)
      MODE_INSERT: begin
        if (!tid_ok || queued[req.thread_id]) begin
          eval_status_next = STAT_IGNORED;
        end else begin
          do_insert_next = 1'b1;
        end
      end
      MODE_REMOVE: begin
        if (!tid_ok || !queued[req.thread_id]) begin
          eval_status_next = STAT_IGNORED;
        end else begin
          kill_next = match_vec;
        end
      end
      MODE_EXTRACT: begin
        kill_next = pick_vec;
        if (pick_vec == '0) begin
          eval_status_next = STAT_EMPTY;
        end
      end
      default: begin
        eval_status_next = STAT_IGNORED;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == ST_EVAL) begin
      kill        <= kill_next;
      do_insert   <= do_insert_next;
      eval_status <= eval_status_next;
    end
    if (start && !busy) begin
      req <= cmd;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  state_next = start ? ST_EVAL : ST_IDLE;
      ST_EVAL:  state_next = ST_APPLY;
      ST_APPLY: state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    busy = (state != ST_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Queued flags per thread id
  always_ff @(posedge clk) begin
    if (rst) begin
      queued <= '0;
    end else if (state == ST_APPLY) begin
      if (do_insert) begin
        queued[req.thread_id] <= 1'b1;
      end else if (kill_any) begin
        queued[kill_tid] <= 1'b0;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (state == ST_APPLY);
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_APPLY) begin
      rsp.found         <= (req.mode == MODE_EXTRACT) && kill_any;
      rsp.chosen_thread <= ((req.mode == MODE_EXTRACT) && kill_any) ? kill_tid : '0;
      rsp.status        <= eval_status;
    end
  end

endmodule
